FILE: hdl/mmgn_pkg.sv
// Shared constants and types for the min/max gray normalizer.
package mmgn_pkg;

    localparam int PIX_IN_W   = 16;
    localparam int PIXEL_BITS = 16;
    localparam int GRAY_W     = 8;
    localparam int NUM_W      = PIXEL_BITS + GRAY_W;
    localparam int CNT_W      = $clog2(GRAY_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_OBSERVE = 2'd1,
        CMD_SCALE   = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic [PIXEL_BITS-1:0] low;
        logic [PIXEL_BITS-1:0] high;
    } t_job;

endpackage

FILE: hdl/mmgn_front.sv
// Front end: accepts transactions, tracks the bounds and issues scale jobs.
module mmgn_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [mmgn_pkg::PIX_IN_W-1:0] i_pixel,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output mmgn_pkg::t_job              o_job
);

    logic                            w_accept;
    logic [mmgn_pkg::PIXEL_BITS-1:0] w_pix;
    logic [mmgn_pkg::PIXEL_BITS-1:0] r_low;
    logic [mmgn_pkg::PIXEL_BITS-1:0] r_high;
    logic                            r_any;

    assign o_ready  = ~i_queue_full;
    assign w_accept = i_valid & o_ready;
    assign w_pix    = i_pixel[mmgn_pkg::PIXEL_BITS-1:0];

    // A scale job carries a snapshot of the bounds as they stand at acceptance.
    assign o_push     = w_accept && (mmgn_pkg::t_cmd'(i_cmd) == mmgn_pkg::CMD_SCALE);
    assign o_job.pix  = w_pix;
    assign o_job.low  = r_low;
    assign o_job.high = r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_any  <= 1'b0;
        end else if (w_accept) begin
            unique case (mmgn_pkg::t_cmd'(i_cmd))
                mmgn_pkg::CMD_CLEAR: begin
                    r_low  <= '0;
                    r_high <= '0;
                    r_any  <= 1'b0;
                end
                mmgn_pkg::CMD_OBSERVE: begin
                    if (!r_any) begin
                        r_low  <= w_pix;
                        r_high <= w_pix;
                        r_any  <= 1'b1;
                    end else begin
                        if (w_pix < r_low) begin
                            r_low <= w_pix;
                        end
                        if (w_pix > r_high) begin
                            r_high <= w_pix;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_low <= r_high))
        else $error("tracked minimum exceeds tracked maximum");
`endif

endmodule

FILE: hdl/mmgn_queue.sv
// Short job queue between the front end and the divider.
module mmgn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mmgn_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output mmgn_pkg::t_job o_job
);

    mmgn_pkg::t_job                r_mem [mmgn_pkg::QUEUE_DEPTH];
    logic [mmgn_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [mmgn_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [mmgn_pkg::QCNT_W-1:0]   r_count;

    assign o_full      = (r_count == mmgn_pkg::QCNT_W'(mmgn_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("pop from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mmgn_pkg::QCNT_W'(mmgn_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: hdl/mmgn_back.sv
// Back end: range setup, restoring division for the gray value, output register.
module mmgn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    input  mmgn_pkg::t_job            i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [mmgn_pkg::GRAY_W-1:0] o_gray
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state                          r_state;
    mmgn_pkg::t_job                  r_job;
    logic [mmgn_pkg::NUM_W-1:0]      r_rem;
    logic [mmgn_pkg::PIXEL_BITS-1:0] r_div;
    logic [mmgn_pkg::CNT_W-1:0]      r_cnt;
    logic [mmgn_pkg::GRAY_W-1:0]     r_q;
    logic                            r_out_valid;
    logic [mmgn_pkg::GRAY_W-1:0]     r_gray;

    logic [mmgn_pkg::PIXEL_BITS-1:0] w_diff;
    logic [mmgn_pkg::PIXEL_BITS-1:0] w_range;
    logic [mmgn_pkg::NUM_W-1:0]      w_num;
    logic [mmgn_pkg::NUM_W-1:0]      w_dsh;
    logic                            w_out_free;
    logic                            w_load;

    assign o_pop      = (r_state == S_IDLE) && i_job_valid;
    assign o_valid    = r_out_valid;
    assign o_gray     = r_gray;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_load     = (r_state == S_OUT) && w_out_free;

    // (pix - low) * 255 is formed as a shift and a subtract.
    assign w_diff  = r_job.pix - r_job.low;
    assign w_range = r_job.high - r_job.low;
    assign w_num   = {w_diff, {mmgn_pkg::GRAY_W{1'b0}}}
                     - mmgn_pkg::NUM_W'(w_diff);
    assign w_dsh   = mmgn_pkg::NUM_W'(r_div) << r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    // Empty range and pixels at or outside the bounds need no division.
                    if (r_job.high <= r_job.low || r_job.pix <= r_job.low) begin
                        r_q     <= '0;
                        r_state <= S_OUT;
                    end else if (r_job.pix >= r_job.high) begin
                        r_q     <= mmgn_pkg::GRAY_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= w_num;
                        r_div   <= w_range;
                        r_q     <= '0;
                        r_cnt   <= mmgn_pkg::CNT_W'(mmgn_pkg::GRAY_W - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_rem >= w_dsh) begin
                        r_rem        <= r_rem - w_dsh;
                        r_q[r_cnt]   <= 1'b1;
                    end
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_gray      <= r_q;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |->
            ({1'b0, r_rem} < ({1'b0, mmgn_pkg::NUM_W'(r_div)}
                << ((mmgn_pkg::CNT_W + 1)'(r_cnt) + 1'b1))))
        else $error("partial remainder outside the quotient range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !w_out_free) |=> (r_state == S_OUT))
        else $error("result dropped while the output register was busy");
`endif

endmodule

FILE: hdl/min_max_gray_normalizer_top.sv
// Top level of the min/max gray normalizer.
//
//   Channel  Direction  Handshake          Payload
//   input    in         i_valid / o_ready  i_cmd[1:0], i_pixel[15:0]
//   output   out        o_valid / i_ready  o_gray[7:0]
//
// Clear and observe transactions are handled in the front end and give no result.
// After acceptance a scale transaction reaches the output register through queue pop,
// range setup, eight restoring-division steps and the load of the output register.
// An empty range or a pixel at or outside the bounds skips the division.
// Reset (i_rst_n, synchronous, active low) clears the bounds, the job queue and the FSM.
// A stalled output holds the back end in its output state; the two-entry job queue then fills and o_ready drops.
module min_max_gray_normalizer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [mmgn_pkg::PIX_IN_W-1:0] i_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mmgn_pkg::GRAY_W-1:0]   o_gray
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_not_empty;
    mmgn_pkg::t_job w_job_in;
    mmgn_pkg::t_job w_job_out;

    mmgn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_pixel      (i_pixel),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    mmgn_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_job_in),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_job       (w_job_out)
    );

    mmgn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_not_empty),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_gray      (o_gray)
    );

endmodule

FILE: sim/min_max_gray_normalizer_top_tb.sv
// Self-checking testbench for the min/max gray normalizer top level.
`timescale 1ns / 100ps

module min_max_gray_normalizer_top_tb;

    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int PHASE_ITEMS   = 600;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the observed bounds and the gray values still owed by the block.
    class gray_expect_board;
        logic [mmgn_pkg::PIXEL_BITS-1:0] low_bound;
        logic [mmgn_pkg::PIXEL_BITS-1:0] high_bound;
        bit                              seen_any;
        logic [mmgn_pkg::GRAY_W-1:0]     gray_due[$];
        int                              mismatch_cnt;

        function new();
            clear_bounds();
            mismatch_cnt = 0;
        endfunction

        function void clear_bounds();
            low_bound  = '0;
            high_bound = '0;
            seen_any   = 1'b0;
        endfunction

        function logic [mmgn_pkg::GRAY_W-1:0] predict_gray(
            logic [mmgn_pkg::PIXEL_BITS-1:0] pix);
            int unsigned num;
            int unsigned span;
            int unsigned quot;
            if (high_bound <= low_bound) return '0;
            if (pix <= low_bound) return '0;
            if (pix >= high_bound) return mmgn_pkg::GRAY_MAX;
            num  = (32'(pix) - 32'(low_bound)) * 32'(mmgn_pkg::GRAY_MAX);
            span = 32'(high_bound) - 32'(low_bound);
            quot = num / span;
            if (quot > 32'(mmgn_pkg::GRAY_MAX)) quot = 32'(mmgn_pkg::GRAY_MAX);
            return quot[mmgn_pkg::GRAY_W-1:0];
        endfunction

        function void note_transaction(mmgn_pkg::t_cmd cmd,
                                       logic [mmgn_pkg::PIX_IN_W-1:0] pixel);
            logic [mmgn_pkg::PIXEL_BITS-1:0] pix;
            pix = pixel[mmgn_pkg::PIXEL_BITS-1:0];
            case (cmd)
                mmgn_pkg::CMD_CLEAR: begin
                    clear_bounds();
                end
                mmgn_pkg::CMD_OBSERVE: begin
                    if (!seen_any) begin
                        low_bound  = pix;
                        high_bound = pix;
                        seen_any   = 1'b1;
                    end else begin
                        if (pix < low_bound) low_bound = pix;
                        if (pix > high_bound) high_bound = pix;
                    end
                end
                mmgn_pkg::CMD_SCALE: begin
                    gray_due = {gray_due, predict_gray(pix)};
                end
                default: begin
                end
            endcase
        endfunction

        function void check_gray(logic [mmgn_pkg::GRAY_W-1:0] got);
            logic [mmgn_pkg::GRAY_W-1:0] want;
            if (gray_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("ERROR: unexpected result transaction, gray=%0d", got);
                return;
            end
            want = gray_due.pop_front();
            if (got !== want) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_LIMIT)
                    $display("ERROR: gray mismatch, expected %0d, got %0d", want, got);
            end
        endfunction

        function int pending();
            return gray_due.size();
        endfunction
    endclass

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [1:0]                      i_cmd   = '0;
    logic [mmgn_pkg::PIX_IN_W-1:0]   i_pixel = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [mmgn_pkg::GRAY_W-1:0]     o_gray;

    gray_expect_board board = new();
    int send_idle   = 19;
    int recv_idle   = 70;
    int sent_cnt    = 0;
    int idle_cycles = 0;

    min_max_gray_normalizer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cmd   (i_cmd),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_gray  (o_gray)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Presents one transaction and holds it until the block takes it.
    task automatic send_item(input mmgn_pkg::t_cmd cmd,
                             input logic [mmgn_pkg::PIX_IN_W-1:0] pixel);
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_pixel <= pixel;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_transaction(cmd, pixel);
        if (cmd != mmgn_pkg::CMD_NONE) sent_cnt++;
        if ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        send_item(mmgn_pkg::CMD_CLEAR, 16'h0000);
        send_item(mmgn_pkg::CMD_SCALE, 16'hFFFF);
        send_item(mmgn_pkg::CMD_OBSERVE, 16'h1234);
        send_item(mmgn_pkg::CMD_SCALE, 16'h1234);
        send_item(mmgn_pkg::CMD_OBSERVE, 16'h0000);
        send_item(mmgn_pkg::CMD_OBSERVE, 16'hFFFF);
        send_item(mmgn_pkg::CMD_SCALE, 16'h0000);
        send_item(mmgn_pkg::CMD_SCALE, 16'hFFFF);
        send_item(mmgn_pkg::CMD_SCALE, 16'h8000);
        send_item(mmgn_pkg::CMD_SCALE, 16'h0001);
        send_item(mmgn_pkg::CMD_SCALE, 16'hFFFE);
        send_item(mmgn_pkg::CMD_NONE, 16'hFFFF);
        send_item(mmgn_pkg::CMD_SCALE, 16'h5555);
        send_item(mmgn_pkg::CMD_CLEAR, 16'hFFFF);
        send_item(mmgn_pkg::CMD_OBSERVE, 16'd2000);
        send_item(mmgn_pkg::CMD_OBSERVE, 16'd1000);
        send_item(mmgn_pkg::CMD_SCALE, 16'd500);
        send_item(mmgn_pkg::CMD_SCALE, 16'd3000);
        send_item(mmgn_pkg::CMD_SCALE, 16'd1500);
        send_item(mmgn_pkg::CMD_SCALE, 16'd1001);
        send_item(mmgn_pkg::CMD_SCALE, 16'd1999);
        send_item(mmgn_pkg::CMD_NONE, 16'h0000);
        send_item(mmgn_pkg::CMD_SCALE, 16'd1000);
        send_item(mmgn_pkg::CMD_SCALE, 16'd2000);
    endtask

    // Mostly clear/observe/scale sequences over a chosen range, with some noise.
    task automatic run_random(input int target);
        int span;
        int lo;
        int hi;
        int n_obs;
        int n_scale;
        int roll;
        logic [mmgn_pkg::PIX_IN_W-1:0] pix;
        while (sent_cnt < target) begin
            if ($urandom_range(0, 99) < 85) begin
                roll = $urandom_range(0, 2);
                span = (roll == 0) ? $urandom_range(0, 3) :
                       (roll == 1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
                lo = $urandom_range(0, 65535 - span);
                hi = lo + span;
                if ($urandom_range(0, 99) < 85)
                    send_item(mmgn_pkg::CMD_CLEAR, 16'($urandom));
                n_obs = $urandom_range(1, 6);
                for (int k = 0; k < n_obs; k++) begin
                    pix = (k == 0) ? 16'(lo) : (k == n_obs - 1) ? 16'(hi) :
                          16'($urandom_range(lo, hi));
                    send_item(mmgn_pkg::CMD_OBSERVE, pix);
                    if ($urandom_range(0, 99) < 5)
                        send_item(mmgn_pkg::CMD_NONE, 16'($urandom));
                end
                n_scale = $urandom_range(1, 8);
                for (int k = 0; k < n_scale; k++) begin
                    roll = $urandom_range(0, 99);
                    pix = (roll < 80) ? 16'($urandom_range(lo, hi)) :
                          (roll < 88) ? 16'((roll < 84) ? lo : hi) : 16'($urandom);
                    send_item(mmgn_pkg::CMD_SCALE, pix);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(mmgn_pkg::t_cmd'($urandom_range(0, 3)), 16'($urandom));
            end
        end
    endtask

    // Result side: check what is accepted and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_gray(o_gray);
        i_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Ends the run if no transaction is accepted on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles == STALL_LIMIT) begin
                $display("min_max_gray_normalizer_top verification failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(sent_cnt + PHASE_ITEMS);

        send_idle = 70;
        recv_idle = 19;
        run_random(sent_cnt + PHASE_ITEMS);

        send_idle = 0;
        recv_idle = 0;
        run_random(sent_cnt + PHASE_ITEMS);

        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatch_cnt == 0 && board.pending() == 0) begin
            $display("min_max_gray_normalizer_top verification clean");
        end else begin
            $display("min_max_gray_normalizer_top verification failed");
        end
        $finish;
    end

endmodule
